// ----- rtl/core/input_event_touch_translator_unit_assert.svh -----
// Assertion macros shared by the translator RTL.
`ifndef INPUT_EVENT_TOUCH_TRANSLATOR_UNIT_ASSERT_SVH
`define INPUT_EVENT_TOUCH_TRANSLATOR_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define ITT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itt assertion failed");

// Expression never holds.
`define ITT_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("itt assertion failed");

`endif

// ----- rtl/core/itt_pkg.sv -----
`default_nettype none
package itt_pkg;

  localparam logic [2:0] CFG_SCREEN_W = 3'd0;
  localparam logic [2:0] CFG_SCREEN_H = 3'd1;
  localparam logic [2:0] CFG_MODE     = 3'd2;
  localparam logic [2:0] CFG_MIN_X    = 3'd3;
  localparam logic [2:0] CFG_MAX_X    = 3'd4;
  localparam logic [2:0] CFG_MIN_Y    = 3'd5;
  localparam logic [2:0] CFG_MAX_Y    = 3'd6;

  localparam logic [2:0] KIND_MOTION  = 3'd0;
  localparam logic [2:0] KIND_TOUCH   = 3'd1;
  localparam logic [2:0] KIND_WHEEL   = 3'd2;
  localparam logic [2:0] KIND_PRESS   = 3'd3;
  localparam logic [2:0] KIND_RELEASE = 3'd4;

  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_REL = 5'd2;
  localparam logic [4:0] EV_ABS = 5'd3;

  localparam logic [9:0] CODE_X          = 10'd0;
  localparam logic [9:0] CODE_Y          = 10'd1;
  localparam logic [9:0] CODE_HWHEEL     = 10'd6;
  localparam logic [9:0] CODE_WHEEL      = 10'd8;
  localparam logic [9:0] CODE_MT_SLOT    = 10'd47;
  localparam logic [9:0] CODE_MT_X       = 10'd53;
  localparam logic [9:0] CODE_MT_Y       = 10'd54;
  localparam logic [9:0] CODE_MT_TRACK   = 10'd57;
  localparam logic [9:0] CODE_BTN_LEFT   = 10'd272;
  localparam logic [9:0] CODE_BTN_TOUCH  = 10'd330;

  localparam logic [31:0] VAL_NONE = 32'hFFFF_FFFF;

  localparam int QDEPTH    = 2;
  localparam int DIV_STEPS = 16;

  typedef struct packed {
    logic [15:0]        screen_w;
    logic [15:0]        screen_h;
    logic [2:0]         mode;
    logic signed [31:0] min_x;
    logic signed [31:0] max_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;
  } cfg_t;

  // One classified event; with scale set, ax/ay hold offsets from the axis minimum.
  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  number;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] rx;
    logic [31:0] ry;
    logic        scale;
    logic [31:0] span_x;
    logic [31:0] span_y;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

// ----- rtl/core/itt_if.sv -----
`default_nettype none
interface itt_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic [9:0]  event_code;
  logic [31:0] event_value;
  modport source (output valid, cmd, event_code, event_value, input ready);
  modport sink (input valid, cmd, event_code, event_value, output ready);
endinterface

interface itt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [9:0]  number;
  logic [31:0] abs_x;
  logic [31:0] abs_y;
  logic [31:0] rel_x;
  logic [31:0] rel_y;
  modport source (output valid, kind, number, abs_x, abs_y, rel_x, rel_y, input ready);
  modport sink (input valid, kind, number, abs_x, abs_y, rel_x, rel_y, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/itt_front.sv -----
`default_nettype none
module itt_front
  import itt_pkg::*;
#(
  parameter int TOUCH_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_cmd,
  input  wire logic [9:0]  in_code,
  input  wire logic [31:0] in_value,
  input  wire qstat_t      q_stat,
  output logic             q_push,
  output cmd_t             q_data
);

  localparam int SW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

  logic [31:0]   last_x_r [TOUCH_SLOTS];
  logic [31:0]   last_y_r [TOUCH_SLOTS];
  logic [SW-1:0] slot_r, slot_nxt;

  logic               accept, emit, wr_x, wr_y, clr, sel_slot;
  logic               mt_mode, mt_both, scr_on, in_rng, span_ok, scale_ok;
  logic signed [31:0] val, xs, ys;
  logic [31:0]        cur_x, cur_y;
  logic               is_axis, is_end;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && emit;
  assign val      = in_value;
  assign mt_mode  = cfg.mode[0];
  assign mt_both  = cfg.mode[0] && cfg.mode[1];
  assign scr_on   = (cfg.screen_w != 16'd0) && (cfg.screen_h != 16'd0);
  assign cur_x    = last_x_r[slot_r];
  assign cur_y    = last_y_r[slot_r];

  // Classify the event and prepare the queue entry.
  always_comb begin
    emit     = 1'b0;
    wr_x     = 1'b0;
    wr_y     = 1'b0;
    clr      = 1'b0;
    sel_slot = 1'b0;
    is_axis  = 1'b0;
    is_end   = 1'b0;
    q_data   = '0;
    xs       = cur_x;
    ys       = cur_y;
    if (!cfg.mode[2]) begin
      case (in_cmd)
        EV_KEY: begin
          if (!mt_both && (val == 32'sd0 || val == 32'sd1)) begin
            emit          = 1'b1;
            q_data.kind   = (val == 32'sd0) ? KIND_RELEASE : KIND_PRESS;
            q_data.number = (in_code == CODE_BTN_TOUCH) ? CODE_BTN_LEFT : in_code;
          end
        end
        EV_REL: begin
          case (in_code)
            CODE_X:      begin emit = 1'b1; q_data.kind = KIND_MOTION; q_data.rx = val; end
            CODE_Y:      begin emit = 1'b1; q_data.kind = KIND_MOTION; q_data.ry = val; end
            CODE_HWHEEL: begin emit = 1'b1; q_data.kind = KIND_WHEEL;  q_data.rx = val; end
            CODE_WHEEL:  begin emit = 1'b1; q_data.kind = KIND_WHEEL;  q_data.ry = val; end
            default: ;
          endcase
        end
        EV_ABS: begin
          case (in_code)
            CODE_WHEEL: begin
              emit        = 1'b1;
              q_data.kind = KIND_WHEEL;
              q_data.ry   = val;
            end
            CODE_X, CODE_Y: begin
              if (!mt_both) begin
                is_axis     = 1'b1;
                wr_x        = (in_code == CODE_X);
                wr_y        = (in_code == CODE_Y);
                q_data.kind = KIND_MOTION;
              end
            end
            CODE_MT_X, CODE_MT_Y: begin
              if (mt_mode) begin
                is_axis     = 1'b1;
                wr_x        = (in_code == CODE_MT_X);
                wr_y        = (in_code == CODE_MT_Y);
                q_data.kind = KIND_TOUCH;
              end
            end
            CODE_MT_TRACK: begin
              if (mt_mode && val == -32'sd1) begin
                is_end      = 1'b1;
                q_data.kind = KIND_TOUCH;
                q_data.rx   = VAL_NONE;
                q_data.ry   = VAL_NONE;
              end
            end
            CODE_MT_SLOT: begin
              sel_slot = mt_mode && (val >= 32'sd0) && (val < $signed(32'(TOUCH_SLOTS)));
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // Form the position for the current slot.
    if (wr_x) xs = val;
    if (wr_y) ys = val;
    if (is_end) begin
      xs = cur_x[31] ? 32'sd0 : $signed(cur_x);
      ys = cur_y[31] ? 32'sd0 : $signed(cur_y);
    end

    span_ok  = (cfg.max_x != cfg.min_x) && (cfg.max_y != cfg.min_y);
    in_rng   = (xs >= cfg.min_x) && (xs <= cfg.max_x) && (ys >= cfg.min_y) &&
               (ys <= cfg.max_y);
    scale_ok = !scr_on || (span_ok && in_rng);

    if (is_axis || is_end) begin
      q_data.number = 10'(slot_r);
      q_data.scale  = scr_on;
      q_data.ax     = scr_on ? 32'(xs - cfg.min_x) : xs;
      q_data.ay     = scr_on ? 32'(ys - cfg.min_y) : ys;
      q_data.span_x = 32'(cfg.max_x - cfg.min_x);
      q_data.span_y = 32'(cfg.max_y - cfg.min_y);
    end
    if (is_axis)
      emit = scale_ok && (xs != -32'sd1) && (ys != -32'sd1);
    if (is_end) begin
      emit = scale_ok;
      clr  = scale_ok;
    end

    slot_nxt = sel_slot ? val[SW-1:0] : slot_r;
  end

  // Update the per-slot positions and the slot select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      for (int i = 0; i < TOUCH_SLOTS; i++) begin
        last_x_r[i] <= VAL_NONE;
        last_y_r[i] <= VAL_NONE;
      end
    end else if (accept) begin
      slot_r <= slot_nxt;
      if (wr_x || clr) last_x_r[slot_r] <= clr ? VAL_NONE : val;
      if (wr_y || clr) last_y_r[slot_r] <= clr ? VAL_NONE : val;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/itt_queue.sv -----
`default_nettype none
module itt_queue
  import itt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  input  wire logic pop,
  output cmd_t      head,
  output qstat_t    stat
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign head       = mem_r[rp_r];
  assign stat.full  = (cnt_r == CW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

  // Store entries.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/itt_back.sv -----
`default_nettype none
module itt_back
  import itt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire cmd_t  head,
  input  wire qstat_t q_stat,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output cmd_t       out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam int CNTW = $clog2(DIV_STEPS + 1);

  logic [1:0]      st_r, st_nxt;
  logic [CNTW-1:0] cnt_r;
  logic [31:0]     remx_r, remy_r, dx_r, dy_r;
  logic [15:0]     qx_r, qy_r;
  cmd_t            hold_r, res_r, fin_res;
  logic            oval_r;
  logic            out_free, load_out;
  logic [47:0]     px, py;
  logic [32:0]     tx, ty;

  assign out_free  = !oval_r || out_ready;
  assign out_valid = oval_r;
  assign out_data  = res_r;
  assign px        = cfg.screen_w * head.ax;
  assign py        = cfg.screen_h * head.ay;
  assign tx        = {remx_r, qx_r[15]};
  assign ty        = {remy_r, qy_r[15]};

  // Sequence pop, division and result load.
  always_comb begin
    st_nxt   = st_r;
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          if (head.scale) begin
            pop    = 1'b1;
            st_nxt = ST_DIV;
          end else if (out_free) begin
            pop      = 1'b1;
            load_out = 1'b1;
          end
        end
      end
      ST_DIV: if (cnt_r == CNTW'(1)) st_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      oval_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) oval_r <= 1'b1;
      else if (out_ready) oval_r <= 1'b0;
    end
  end

  // Restoring division, one quotient bit per axis each cycle.
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && pop && head.scale) begin
      hold_r <= head;
      dx_r   <= head.span_x;
      dy_r   <= head.span_y;
      remx_r <= px[47:16];
      remy_r <= py[47:16];
      qx_r   <= px[15:0];
      qy_r   <= py[15:0];
      cnt_r  <= CNTW'(DIV_STEPS);
    end else if (st_r == ST_DIV) begin
      cnt_r <= cnt_r - 1'b1;
      if (tx >= {1'b0, dx_r}) begin
        remx_r <= 32'(tx - {1'b0, dx_r});
        qx_r   <= {qx_r[14:0], 1'b1};
      end else begin
        remx_r <= tx[31:0];
        qx_r   <= {qx_r[14:0], 1'b0};
      end
      if (ty >= {1'b0, dy_r}) begin
        remy_r <= 32'(ty - {1'b0, dy_r});
        qy_r   <= {qy_r[14:0], 1'b1};
      end else begin
        remy_r <= ty[31:0];
        qy_r   <= {qy_r[14:0], 1'b0};
      end
    end
  end

  // Merge the quotients into the held event.
  always_comb begin
    fin_res    = hold_r;
    fin_res.ax = {16'd0, qx_r};
    fin_res.ay = {16'd0, qy_r};
  end

  // Hold the result for the output channel.
  always_ff @(posedge clk) begin
    if (load_out) begin
      res_r <= (st_r == ST_FIN) ? fin_res : head;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/input_event_touch_translator_unit.sv -----
// Throughput: one unscaled event per cycle while the output is ready; a scaled
// position holds the back end through the 16-step shift-subtract divider (both
// axes in parallel), then until its result is taken into the output register.
// A two-entry queue lets input acceptance continue during a division.
// Reset (synchronous, rst_n low) clears config registers, the slot select and sets
// all slot positions to unknown; no clearing pass is needed.
`default_nettype none
module input_event_touch_translator_unit
  import itt_pkg::*;
#(
  parameter int TOUCH_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  itt_in_if.sink           in_ch,
  itt_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [31:0] cfg_wdata
);

  cfg_t   cfg_r;
  cmd_t   q_in, q_head, res;
  qstat_t q_stat;
  logic   q_push, q_pop, in_ready;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SCREEN_W: cfg_r.screen_w <= cfg_wdata[15:0];
        CFG_SCREEN_H: cfg_r.screen_h <= cfg_wdata[15:0];
        CFG_MODE:     cfg_r.mode     <= cfg_wdata[2:0];
        CFG_MIN_X:    cfg_r.min_x    <= cfg_wdata;
        CFG_MAX_X:    cfg_r.max_x    <= cfg_wdata;
        CFG_MIN_Y:    cfg_r.min_y    <= cfg_wdata;
        CFG_MAX_Y:    cfg_r.max_y    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;

  itt_front #(.TOUCH_SLOTS(TOUCH_SLOTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_cmd   (in_ch.cmd),
    .in_code  (in_ch.event_code),
    .in_value (in_ch.event_value),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  itt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  itt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res)
  );

  assign out_ch.kind   = res.kind;
  assign out_ch.number = res.number;
  assign out_ch.abs_x  = res.ax;
  assign out_ch.abs_y  = res.ay;
  assign out_ch.rel_x  = res.rx;
  assign out_ch.rel_y  = res.ry;

`include "input_event_touch_translator_unit_assert.svh"

  `ITT_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full)
  `ITT_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty)
  `ITT_ASSERT_NEVER(a_q_stat, q_stat.full && q_stat.empty)

endmodule
`default_nettype wire

// ----- test/input_event_touch_translator_unit_test.sv -----
`default_nettype none
module input_event_touch_translator_unit_test;
  import itt_pkg::*;

  localparam int SLOTS      = 16;
  localparam int SETTLE     = 40;
  localparam int STALL_MAX  = 5000;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_SETTINGS = 9;

  typedef struct {
    logic [2:0]  kind;
    logic [9:0]  number;
    logic [31:0] abs_x;
    logic [31:0] abs_y;
    logic [31:0] rel_x;
    logic [31:0] rel_y;
  } ptr_event_t;

  typedef struct {
    logic [4:0]  cmd;
    logic [9:0]  code;
    logic [31:0] value;
    bit          literal;
    bit          has_event;
    ptr_event_t  ev;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  itt_in_if  in_ch ();
  itt_out_if out_ch ();

  input_event_touch_translator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's registers and slot state
  logic [15:0] sh_width, sh_height;
  logic [2:0]  sh_mode;
  longint      sh_min_x, sh_max_x, sh_min_y, sh_max_y;
  longint      last_x [SLOTS];
  longint      last_y [SLOTS];
  int          cur_slot;

  ptr_event_t  pending_events[$];
  stim_row_t   directed_rows[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          quiet_cycles = 0;

  function automatic ptr_event_t mk_event(logic [2:0] kind, logic [9:0] number,
                                          longint ax, longint ay, longint rx, longint ry);
    ptr_event_t e;
    e.kind = kind;
    e.number = number;
    e.abs_x = ax[31:0];
    e.abs_y = ay[31:0];
    e.rel_x = rx[31:0];
    e.rel_y = ry[31:0];
    return e;
  endfunction

  // Map a position onto the screen; zero means the event is dropped
  function automatic bit map_to_screen(inout longint x, inout longint y);
    longint sx, sy;
    longint unsigned qx, qy;
    if (sh_width == 0 || sh_height == 0) return 1'b1;
    sx = sh_max_x - sh_min_x;
    sy = sh_max_y - sh_min_y;
    if (sx == 0 || sy == 0) return 1'b0;
    if (x < sh_min_x || x > sh_max_x || y < sh_min_y || y > sh_max_y) return 1'b0;
    qx = (longint'(sh_width) * longint'(x - sh_min_x)) / longint'(sx);
    qy = (longint'(sh_height) * longint'(y - sh_min_y)) / longint'(sy);
    x = longint'(qx);
    y = longint'(qy);
    return 1'b1;
  endfunction

  function automatic bit axis_event(bit is_x, bit single, longint v, output ptr_event_t e);
    longint x, y;
    if (is_x) last_x[cur_slot] = v;
    else last_y[cur_slot] = v;
    x = last_x[cur_slot];
    y = last_y[cur_slot];
    if (x == -1 || y == -1) return 1'b0;
    if (!map_to_screen(x, y)) return 1'b0;
    e = mk_event(single ? KIND_MOTION : KIND_TOUCH, cur_slot[9:0], x, y, 0, 0);
    return 1'b1;
  endfunction

  // Translate one evdev event and advance the shadow state
  function automatic bit translate_event(logic [4:0] cmd, logic [9:0] code,
                                         logic [31:0] raw, output ptr_event_t e);
    longint v, x, y;
    bit mt, mt_both;
    v = longint'(signed'(raw));
    mt = sh_mode[0];
    mt_both = sh_mode[0] && sh_mode[1];
    if (sh_mode[2]) return 1'b0;
    if (cmd == EV_KEY) begin
      if (mt_both) return 1'b0;
      if (code == CODE_BTN_TOUCH) code = CODE_BTN_LEFT;
      if (v == 0) begin
        e = mk_event(KIND_RELEASE, code, 0, 0, 0, 0);
        return 1'b1;
      end
      if (v == 1) begin
        e = mk_event(KIND_PRESS, code, 0, 0, 0, 0);
        return 1'b1;
      end
      return 1'b0;
    end
    if (cmd == EV_REL) begin
      case (code)
        CODE_X: e = mk_event(KIND_MOTION, 0, 0, 0, v, 0);
        CODE_Y: e = mk_event(KIND_MOTION, 0, 0, 0, 0, v);
        CODE_HWHEEL: e = mk_event(KIND_WHEEL, 0, 0, 0, v, 0);
        CODE_WHEEL: e = mk_event(KIND_WHEEL, 0, 0, 0, 0, v);
        default: return 1'b0;
      endcase
      return 1'b1;
    end
    if (cmd == EV_ABS) begin
      case (code)
        CODE_WHEEL: begin
          e = mk_event(KIND_WHEEL, 0, 0, 0, 0, v);
          return 1'b1;
        end
        CODE_X: return mt_both ? 1'b0 : axis_event(1'b1, 1'b1, v, e);
        CODE_Y: return mt_both ? 1'b0 : axis_event(1'b0, 1'b1, v, e);
        CODE_MT_X: return !mt ? 1'b0 : axis_event(1'b1, 1'b0, v, e);
        CODE_MT_Y: return !mt ? 1'b0 : axis_event(1'b0, 1'b0, v, e);
        CODE_MT_TRACK: begin
          if (!mt || v != -1) return 1'b0;
          x = last_x[cur_slot] < 0 ? 0 : last_x[cur_slot];
          y = last_y[cur_slot] < 0 ? 0 : last_y[cur_slot];
          if (!map_to_screen(x, y)) return 1'b0;
          e = mk_event(KIND_TOUCH, cur_slot[9:0], x, y, -1, -1);
          last_x[cur_slot] = -1;
          last_y[cur_slot] = -1;
          return 1'b1;
        end
        CODE_MT_SLOT: begin
          if (mt && v >= 0 && v < SLOTS) cur_slot = int'(v);
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // Check each output transaction against the oldest pending event
  always @(posedge clk) begin
    ptr_event_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected event kind", 32'(out_ch.kind), 32'hx);
      end else begin
        w = pending_events.pop_front();
        if (out_ch.kind !== w.kind) report_mismatch("kind", 32'(out_ch.kind), 32'(w.kind));
        if (out_ch.number !== w.number)
          report_mismatch("number", 32'(out_ch.number), 32'(w.number));
        if (out_ch.abs_x !== w.abs_x) report_mismatch("abs_x", out_ch.abs_x, w.abs_x);
        if (out_ch.abs_y !== w.abs_y) report_mismatch("abs_y", out_ch.abs_y, w.abs_y);
        if (out_ch.rel_x !== w.rel_x) report_mismatch("rel_x", out_ch.rel_x, w.rel_x);
        if (out_ch.rel_y !== w.rel_y) report_mismatch("rel_y", out_ch.rel_y, w.rel_y);
      end
    end
  end

  // Randomly stall the result side
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_SCREEN_W: sh_width = data[15:0];
      CFG_SCREEN_H: sh_height = data[15:0];
      CFG_MODE: sh_mode = data[2:0];
      CFG_MIN_X: sh_min_x = longint'(signed'(data));
      CFG_MAX_X: sh_max_x = longint'(signed'(data));
      CFG_MIN_Y: sh_min_y = longint'(signed'(data));
      CFG_MAX_Y: sh_max_y = longint'(signed'(data));
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] w, logic [15:0] h, logic [2:0] mode,
                           logic [31:0] mnx, logic [31:0] mxx,
                           logic [31:0] mny, logic [31:0] mxy);
    write_reg(CFG_SCREEN_W, 32'(w));
    write_reg(CFG_SCREEN_H, 32'(h));
    write_reg(CFG_MODE, 32'(mode));
    write_reg(CFG_MIN_X, mnx);
    write_reg(CFG_MAX_X, mxx);
    write_reg(CFG_MIN_Y, mny);
    write_reg(CFG_MAX_Y, mxy);
    cfg_we <= 1'b0;
  endtask

  // Send one input transaction and queue what it should produce
  task automatic send_event(stim_row_t r);
    ptr_event_t e;
    bit has;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= r.cmd;
    in_ch.event_code <= r.code;
    in_ch.event_value <= r.value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has = translate_event(r.cmd, r.code, r.value, e);
    if (r.literal) begin
      if (r.has_event) pending_events.push_back(r.ev);
    end else if (has) begin
      pending_events.push_back(e);
    end
  endtask

  // Hold until every pending event is out, then let the pipeline settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic stim_row_t row(logic [4:0] cmd, logic [9:0] code, logic [31:0] value,
                                    bit literal, bit has_event, ptr_event_t ev);
    stim_row_t r;
    r.cmd = cmd;
    r.code = code;
    r.value = value;
    r.literal = literal;
    r.has_event = has_event;
    r.ev = ev;
    return r;
  endfunction

  function automatic logic [31:0] coord(longint lo, longint hi);
    int pick;
    longint unsigned span, off;
    pick = $urandom_range(99);
    if (pick < 10) return 32'hFFFF_FFFF;
    if (pick < 20 || lo > hi) return $urandom;
    span = longint'(hi - lo) + 1;
    off = {$urandom, $urandom} % span;
    return 32'(lo + longint'(off));
  endfunction

  // Mostly well-formed touch traffic, some noise
  function automatic stim_row_t random_row();
    ptr_event_t none;
    int pick;
    logic [9:0] code;
    logic [31:0] v;
    none = mk_event(KIND_MOTION, 0, 0, 0, 0, 0);
    pick = $urandom_range(99);
    if (pick < 12) begin
      code = ($urandom_range(1) == 0) ? CODE_BTN_TOUCH : 10'($urandom_range(767));
      case ($urandom_range(3))
        0: v = 0;
        1: v = 1;
        2: v = 2;
        default: v = $urandom;
      endcase
      return row(EV_KEY, code, v, 0, 0, none);
    end
    if (pick < 24) begin
      case ($urandom_range(4))
        0: code = CODE_X;
        1: code = CODE_Y;
        2: code = CODE_HWHEEL;
        3: code = CODE_WHEEL;
        default: code = 10'($urandom);
      endcase
      return row(EV_REL, code, $urandom, 0, 0, none);
    end
    if (pick < 40) begin
      if ($urandom_range(1) == 0) return row(EV_ABS, CODE_X, coord(sh_min_x, sh_max_x), 0, 0, none);
      return row(EV_ABS, CODE_Y, coord(sh_min_y, sh_max_y), 0, 0, none);
    end
    if (pick < 70) begin
      if ($urandom_range(1) == 0)
        return row(EV_ABS, CODE_MT_X, coord(sh_min_x, sh_max_x), 0, 0, none);
      return row(EV_ABS, CODE_MT_Y, coord(sh_min_y, sh_max_y), 0, 0, none);
    end
    if (pick < 78) begin
      v = ($urandom_range(4) != 0) ? 32'($urandom_range(SLOTS - 1)) : $urandom;
      return row(EV_ABS, CODE_MT_SLOT, v, 0, 0, none);
    end
    if (pick < 86) begin
      v = ($urandom_range(4) != 0) ? 32'hFFFF_FFFF : $urandom;
      return row(EV_ABS, CODE_MT_TRACK, v, 0, 0, none);
    end
    if (pick < 90) return row(EV_ABS, CODE_WHEEL, $urandom, 0, 0, none);
    return row(5'($urandom), 10'($urandom), $urandom, 0, 0, none);
  endfunction

  task automatic apply_setting(int n);
    case (n)
      0: write_all(16'd1920, 16'd1080, 3'd1, 32'd0, 32'd4095, 32'd0, 32'd4095);
      1: write_all(16'hFFFF, 16'hFFFF, 3'd3, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
      2: write_all(16'd0, 16'd0, 3'd0, $urandom, $urandom, $urandom, $urandom);
      3: write_all(16'd800, 16'd0, 3'd1, 32'd0, 32'd100, 32'd0, 32'd100);
      4: write_all(16'd640, 16'd480, 3'd5, 32'd0, 32'd1000, 32'd0, 32'd1000);
      5: write_all(16'd100, 16'd100, 3'd2, 32'd500, 32'd10, 32'hFFFF_FF00, 32'd255);
      6: write_all(16'($urandom), 16'($urandom), 3'($urandom), 32'hFFFF_F000, 32'd3000,
                   32'd7, 32'd7 + $urandom_range(5000));
      7: write_all(16'd1, 16'd1, 3'd1, 32'd0, 32'd50, 32'd20, 32'd20);
      default: write_all(16'($urandom), 16'hFFFF, 3'd7, 32'd0, 32'd10, 32'd0, 32'd10);
    endcase
  endtask

  initial begin
    ptr_event_t none;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.event_code = '0;
    in_ch.event_value = '0;
    out_ch.ready = 1'b0;
    sh_width = 0;
    sh_height = 0;
    sh_mode = 0;
    sh_min_x = 0;
    sh_max_x = 0;
    sh_min_y = 0;
    sh_max_y = 0;
    cur_slot = 0;
    for (int i = 0; i < SLOTS; i++) begin
      last_x[i] = -1;
      last_y[i] = -1;
    end
    none = mk_event(KIND_MOTION, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no scaling, single touch
    directed_rows.push_back(row(EV_KEY, CODE_BTN_TOUCH, 32'd1, 1, 1,
                                mk_event(KIND_PRESS, CODE_BTN_LEFT, 0, 0, 0, 0)));
    directed_rows.push_back(row(EV_KEY, 10'd767, 32'd0, 1, 1,
                                mk_event(KIND_RELEASE, 10'd767, 0, 0, 0, 0)));
    directed_rows.push_back(row(EV_KEY, 10'd30, 32'd2, 1, 0, none));
    directed_rows.push_back(row(EV_KEY, 10'd30, 32'h7FFF_FFFF, 1, 0, none));
    directed_rows.push_back(row(EV_REL, CODE_X, 32'h8000_0000, 1, 1,
                                mk_event(KIND_MOTION, 0, 0, 0, 32'h8000_0000, 0)));
    directed_rows.push_back(row(EV_REL, CODE_Y, 32'h7FFF_FFFF, 1, 1,
                                mk_event(KIND_MOTION, 0, 0, 0, 0, 32'h7FFF_FFFF)));
    directed_rows.push_back(row(EV_REL, CODE_HWHEEL, 32'd3, 1, 1,
                                mk_event(KIND_WHEEL, 0, 0, 0, 3, 0)));
    directed_rows.push_back(row(EV_REL, CODE_WHEEL, 32'hFFFF_FFFF, 1, 1,
                                mk_event(KIND_WHEEL, 0, 0, 0, 0, -1)));
    directed_rows.push_back(row(EV_REL, 10'd2, 32'd9, 1, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_WHEEL, 32'd7, 1, 1,
                                mk_event(KIND_WHEEL, 0, 0, 0, 0, 7)));
    directed_rows.push_back(row(EV_ABS, CODE_X, 32'd100, 1, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_Y, 32'd200, 1, 1,
                                mk_event(KIND_MOTION, 0, 100, 200, 0, 0)));
    directed_rows.push_back(row(EV_ABS, CODE_X, 32'hFFFF_FFFF, 1, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_Y, 32'd5, 1, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_X, 32'h7FFF_FFFF, 1, 1,
                                mk_event(KIND_MOTION, 0, 32'h7FFF_FFFF, 5, 0, 0)));
    directed_rows.push_back(row(EV_ABS, CODE_MT_X, 32'd1, 1, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_SLOT, 32'd2, 1, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_TRACK, 32'hFFFF_FFFF, 1, 0, none));
    directed_rows.push_back(row(5'd0, 10'd0, 32'd0, 1, 0, none));
    directed_rows.push_back(row(5'd4, 10'd4, 32'd1, 1, 0, none));
    directed_rows.push_back(row(5'd31, 10'h3FF, 32'hFFFF_FFFF, 1, 0, none));
    directed_rows.push_back(row(EV_ABS, 10'd767, 32'd1, 1, 0, none));
    foreach (directed_rows[i]) send_event(directed_rows[i]);
    drain();

    // Multi-touch with scaling
    apply_setting(0);
    directed_rows.delete();
    directed_rows.push_back(row(EV_ABS, CODE_MT_SLOT, 32'd15, 0, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_X, 32'd4095, 0, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_Y, 32'd0, 0, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_Y, 32'd5000, 0, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_TRACK, 32'd5, 0, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_TRACK, 32'hFFFF_FFFF, 0, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_SLOT, 32'd16, 0, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_SLOT, 32'hFFFF_FFFF, 0, 0, none));
    directed_rows.push_back(row(EV_ABS, CODE_MT_TRACK, 32'hFFFF_FFFF, 0, 0, none));
    foreach (directed_rows[i]) send_event(directed_rows[i]);
    drain();

    // Random traffic over every setting and idling pattern
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 79; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 79; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      apply_setting(p);
      for (int i = 0; i < PHASE_ITEMS; i++) send_event(random_row());
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
